// File: rtl/servo_enable_sequencer_core_macros.svh
// assertion macros for the servo enable sequencer checker
`ifndef SERVO_ENABLE_SEQUENCER_CORE_MACROS_SVH
`define SERVO_ENABLE_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define SES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("servo enable sequencer: property violated");

// next-cycle implication
`define SES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("servo enable sequencer: property violated");

`endif

// File: rtl/ses_pkg.sv
// ----------------------------------------------------------------------------
// ses_pkg
// Types and constants shared by the servo enable sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ses_pkg;

  localparam int unsigned WAIT_COUNT_WIDTH_DEF = 16;
  localparam int unsigned BRKOFF_TICKS         = 20;
  localparam int unsigned POWER_QUAL_TICKS     = 8;
  localparam int unsigned POWER_COUNT_WIDTH    = 4;

  localparam int unsigned IN_TDATA_WIDTH  = 40;
  localparam int unsigned OUT_TDATA_WIDTH = 16;
  localparam int unsigned CFG_INDEX_WIDTH = 2;
  localparam int unsigned CFG_DATA_WIDTH  = 31;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BRAKE_PRESENT    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BRAKE_HOLD_TIME  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ZERO_SPEED_LIMIT = 2'd2;

  // run modes
  localparam logic [1:0] MODE_POSITION = 2'd0;
  localparam logic [1:0] MODE_SPEED    = 2'd1;
  localparam logic [1:0] MODE_TORQUE   = 2'd2;
  localparam logic [1:0] MODE_INVALID  = 2'd3;

  typedef enum logic [2:0] {
    ST_INACTIVE = 3'd0,
    ST_BRKOFF   = 3'd1,
    ST_ACTIVE   = 3'd2,
    ST_PREPARE  = 3'd3,
    ST_PWMOFF   = 3'd4
  } ses_seq_e;

  typedef struct packed {
    logic        brake_present;
    logic [15:0] brake_hold_time;
    logic [30:0] zero_speed_limit;
  } ses_cfg_t;

  typedef struct packed {
    logic               terminal_ready;
    logic               error_present;
    logic               servo_on;
    logic [1:0]         requested_mode;
    logic signed [31:0] speed_feedback;
  } ses_item_t;

  typedef struct packed {
    logic pwm;
    logic brk;
    logic apr;
    logic asr;
    logic acr;
  } ses_flags_t;

  // sequencer state without the wait counter, whose width is a parameter
  typedef struct packed {
    ses_seq_e                     seq;
    logic                         ready;
    logic [1:0]                   cur_mode;
    logic [1:0]                   pend_mode;
    logic [POWER_COUNT_WIDTH-1:0] power_count;
    logic                         power_ok;
    ses_flags_t                   flags;
  } ses_state_t;

  typedef struct packed {
    logic [2:0] sequencer_state;
    logic       pwm_enable;
    logic       brake_release;
    logic       position_loop_run;
    logic       speed_loop_run;
    logic       current_loop_run;
    logic       servo_ready;
    logic       no_alarm;
    logic       power_ready;
    logic       kernel_fault;
    logic [1:0] active_mode;
    logic       run_allowed;
  } ses_result_t;

  // loop run flags for a mode, pwm and brake left as they are
  function automatic ses_flags_t mode_flags(input ses_flags_t f, input logic [1:0] mode);
    ses_flags_t r;
    r     = f;
    r.apr = (mode == MODE_POSITION);
    r.asr = (mode == MODE_POSITION) || (mode == MODE_SPEED);
    r.acr = (mode != MODE_INVALID);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/ses_step.sv
// ----------------------------------------------------------------------------
// ses_step
// One control tick: alarm, power-ready debounce, servo-ready and the
// five-state enable sequencer, all as combinational next-state logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ses_step #(
  parameter int unsigned WAIT_COUNT_WIDTH = ses_pkg::WAIT_COUNT_WIDTH_DEF
) (
  input  ses_pkg::ses_cfg_t            cfg_i,
  input  ses_pkg::ses_item_t           item_i,
  input  ses_pkg::ses_state_t          state_i,
  input  logic [WAIT_COUNT_WIDTH-1:0]  wait_i,
  output ses_pkg::ses_state_t          state_o,
  output logic [WAIT_COUNT_WIDTH-1:0]  wait_o,
  output ses_pkg::ses_result_t         result_o
);

  import ses_pkg::*;

  localparam int unsigned CMP_W = (WAIT_COUNT_WIDTH > 16) ? WAIT_COUNT_WIDTH : 16;

  logic                        no_alarm;
  logic                        pok_d;
  logic [POWER_COUNT_WIDTH-1:0] pcnt_d;
  logic [POWER_COUNT_WIDTH-1:0] pcnt_inc;
  logic                        run_cond;
  logic                        near_zero;
  logic                        brk_wait;
  logic                        hold_wait;
  logic [WAIT_COUNT_WIDTH-1:0] wait_inc;
  logic signed [32:0]          speed_x;
  logic signed [32:0]          lim_x;
  logic                        fault;
  ses_seq_e                    seq_d;
  ses_state_t                  st_d;
  logic [WAIT_COUNT_WIDTH-1:0] wait_d;

  assign no_alarm = !item_i.error_present;
  assign pcnt_inc = state_i.power_count + 1'b1;

  // power-ready debounce: ninth consecutive ready tick qualifies
  always_comb begin
    pcnt_d = state_i.power_count;
    pok_d  = state_i.power_ok;
    if (item_i.terminal_ready) begin
      if (!state_i.power_ok) begin
        if (pcnt_inc > POWER_COUNT_WIDTH'(POWER_QUAL_TICKS)) begin
          pcnt_d = '0;
          pok_d  = 1'b1;
        end else begin
          pcnt_d = pcnt_inc;
        end
      end
    end else begin
      pcnt_d = '0;
      pok_d  = 1'b0;
    end
  end

  assign run_cond  = pok_d && no_alarm && item_i.servo_on;
  assign speed_x   = 33'(item_i.speed_feedback);
  assign lim_x     = $signed({2'b00, cfg_i.zero_speed_limit});
  assign near_zero = (speed_x < lim_x) && (speed_x > -lim_x);
  assign wait_inc  = wait_i + 1'b1;
  assign brk_wait  = cfg_i.brake_present && (CMP_W'(wait_i) < CMP_W'(BRKOFF_TICKS));
  assign hold_wait = cfg_i.brake_present &&
                     (CMP_W'(wait_inc) < CMP_W'(cfg_i.brake_hold_time[15:1]));

  // next sequencer state
  always_comb begin
    seq_d = state_i.seq;
    unique case (state_i.seq)
      ST_INACTIVE: begin
        if (pok_d && no_alarm) seq_d = ST_BRKOFF;
      end
      ST_BRKOFF: begin
        if (!brk_wait) seq_d = ST_ACTIVE;
      end
      ST_ACTIVE: begin
        if (run_cond && (item_i.requested_mode == state_i.cur_mode)) seq_d = ST_ACTIVE;
        else seq_d = ST_PREPARE;
      end
      ST_PREPARE: begin
        if (!state_i.ready) seq_d = ST_PWMOFF;
        else if (near_zero) seq_d = ST_ACTIVE;
        else if (run_cond && (item_i.requested_mode == state_i.cur_mode)) seq_d = ST_ACTIVE;
        else seq_d = ST_PREPARE;
      end
      ST_PWMOFF: begin
        if (!pok_d || !no_alarm || !hold_wait) seq_d = ST_INACTIVE;
      end
      default: seq_d = ST_INACTIVE;
    endcase
  end

  // flags, mode, ready flag and wait counter
  always_comb begin
    st_d             = state_i;
    st_d.power_count = pcnt_d;
    st_d.power_ok    = pok_d;
    wait_d           = wait_i;
    fault            = 1'b0;
    unique case (state_i.seq)
      ST_INACTIVE: begin
        if (pok_d && no_alarm) begin
          // servo-on ignored, speed mode forced on the way out
          st_d.ready    = 1'b1;
          st_d.cur_mode = MODE_SPEED;
          st_d.flags    = mode_flags(state_i.flags, MODE_SPEED);
          wait_d        = '0;
        end else begin
          st_d.flags.apr = 1'b0;
          st_d.flags.asr = 1'b0;
          st_d.flags.acr = 1'b0;
          st_d.flags.pwm = 1'b0;
          st_d.ready     = 1'b0;
        end
      end
      ST_BRKOFF: begin
        st_d.flags.pwm = 1'b1;
        if (brk_wait) begin
          wait_d         = wait_inc;
          st_d.flags.brk = 1'b0;
        end else begin
          st_d.flags.brk = 1'b1;
          wait_d         = '0;
        end
      end
      ST_ACTIVE: begin
        if (run_cond) begin
          st_d.ready     = 1'b1;
          st_d.pend_mode = item_i.requested_mode;
        end else begin
          st_d.ready = 1'b0;
        end
      end
      ST_PREPARE: begin
        if (state_i.ready) begin
          if (near_zero) begin
            st_d.cur_mode = state_i.pend_mode;
            st_d.flags    = mode_flags(state_i.flags, state_i.pend_mode);
            fault         = (state_i.pend_mode == MODE_INVALID);
          end else if (!run_cond) begin
            st_d.ready = 1'b0;
          end else begin
            st_d.pend_mode = item_i.requested_mode;
          end
        end else begin
          wait_d = '0;
        end
      end
      ST_PWMOFF: begin
        st_d.flags.brk = 1'b0;
        if (!pok_d || !no_alarm) begin
          st_d.flags.pwm = 1'b0;
          wait_d         = '0;
        end else if (hold_wait) begin
          st_d.flags.pwm = 1'b1;
          wait_d         = wait_inc;
        end else begin
          st_d.flags.pwm = 1'b0;
          wait_d         = '0;
        end
      end
      default: fault = 1'b1;
    endcase
    st_d.seq = seq_d;
  end

  assign state_o = st_d;
  assign wait_o  = wait_d;

  always_comb begin
    result_o.sequencer_state   = st_d.seq;
    result_o.pwm_enable        = st_d.flags.pwm;
    result_o.brake_release     = st_d.flags.brk;
    result_o.position_loop_run = st_d.flags.apr;
    result_o.speed_loop_run    = st_d.flags.asr;
    result_o.current_loop_run  = st_d.flags.acr;
    result_o.servo_ready       = no_alarm && pok_d;
    result_o.no_alarm          = no_alarm;
    result_o.power_ready       = pok_d;
    result_o.kernel_fault      = fault;
    result_o.active_mode       = st_d.cur_mode;
    result_o.run_allowed       = st_d.ready;
  end

endmodule

`default_nettype wire

// File: rtl/servo_enable_sequencer_core.sv
// Servo enable sequencer core.
// Each word on the slave stream is one control tick carrying terminal ready,
// error present, servo-on, the requested run mode and the signed speed
// feedback. Each tick yields exactly one word on the master stream with the
// sequencer state, PWM enable, brake release, loop run flags, servo ready,
// alarm, power ready, kernel fault, active mode and run-allowed flag.
// A tick is taken into an input register, evaluated by the combinational
// step logic and written, together with the new sequencer state, into the
// output register, from which m_axis_tvalid is driven; throughput is one
// word per cycle while the receiver does not stall.
// When the receiver stalls, the result word holds and one more tick can be
// taken into the input register; after that s_axis_tready drops.
// Reset clears both valid flags and the sequencer (inactive, speed mode,
// all drive flags off, power not ready) and loads the register defaults:
// brake present, hold time 200, zero-speed limit 8389.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i
// while no tick is in flight; writes to unused indexes are ignored.
// ----------------------------------------------------------------------------
// servo_enable_sequencer_core
// Top level: stream ports, configuration registers, pipeline registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module servo_enable_sequencer_core #(
  parameter int unsigned WAIT_COUNT_WIDTH = ses_pkg::WAIT_COUNT_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ses_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index_i,
  input  logic [ses_pkg::CFG_DATA_WIDTH-1:0]   cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // terminal_ready, error_present, servo_on, requested_mode[1:0],
  // speed_feedback[31:0], zero fill
  input  logic [ses_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sequencer_state[2:0], pwm_enable, brake_release, position_loop_run,
  // speed_loop_run, current_loop_run, servo_ready, no_alarm, power_ready,
  // kernel_fault, active_mode[1:0], run_allowed, zero fill
  output logic [ses_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);

  import ses_pkg::*;

  ses_cfg_t                    cfg_q;
  logic                        in_valid_q;
  ses_item_t                   in_q;
  ses_item_t                   in_d;
  logic                        out_valid_q;
  ses_result_t                 out_q;
  ses_result_t                 res_d;
  ses_state_t                  state_q;
  ses_state_t                  state_d;
  logic [WAIT_COUNT_WIDTH-1:0] wait_q;
  logic [WAIT_COUNT_WIDTH-1:0] wait_d;
  logic                        advance;
  logic                        s_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_present    <= 1'b1;
      cfg_q.brake_hold_time  <= 16'd200;
      cfg_q.zero_speed_limit <= 31'd8389;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_BRAKE_PRESENT:    cfg_q.brake_present    <= cfg_data_i[0];
        REG_BRAKE_HOLD_TIME:  cfg_q.brake_hold_time  <= cfg_data_i[15:0];
        REG_ZERO_SPEED_LIMIT: cfg_q.zero_speed_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  assign in_d.terminal_ready = s_axis_tdata[0];
  assign in_d.error_present  = s_axis_tdata[1];
  assign in_d.servo_on       = s_axis_tdata[2];
  assign in_d.requested_mode = s_axis_tdata[4:3];
  assign in_d.speed_feedback = $signed(s_axis_tdata[36:5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) begin
      in_q <= in_d;
    end
  end

  ses_step #(
    .WAIT_COUNT_WIDTH(WAIT_COUNT_WIDTH)
  ) u_step (
    .cfg_i    (cfg_q),
    .item_i   (in_q),
    .state_i  (state_q),
    .wait_i   (wait_q),
    .state_o  (state_d),
    .wait_o   (wait_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.seq         <= ST_INACTIVE;
      state_q.ready       <= 1'b0;
      state_q.cur_mode    <= MODE_SPEED;
      state_q.pend_mode   <= MODE_SPEED;
      state_q.power_count <= '0;
      state_q.power_ok    <= 1'b0;
      state_q.flags       <= '0;
      wait_q              <= '0;
    end else if (advance) begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_q.run_allowed,
                          out_q.active_mode,
                          out_q.kernel_fault,
                          out_q.power_ready,
                          out_q.no_alarm,
                          out_q.servo_ready,
                          out_q.current_loop_run,
                          out_q.speed_loop_run,
                          out_q.position_loop_run,
                          out_q.brake_release,
                          out_q.pwm_enable,
                          out_q.sequencer_state};

endmodule

`default_nettype wire

// File: rtl/ses_checker.sv
// ----------------------------------------------------------------------------
// ses_checker
// Port-level properties of the servo enable sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "servo_enable_sequencer_core_macros.svh"

module ses_checker (
  input wire                                 clk_i,
  input wire                                 rst_ni,
  input wire                                 m_axis_tvalid,
  input wire                                 m_axis_tready,
  input wire [ses_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata
);

  import ses_pkg::*;

  // servo ready is power ready and no alarm
  `SES_ASSERT_IMP(a_servo_ready, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[8] == (m_axis_tdata[9] && m_axis_tdata[10]))

  // only the five sequencer states are reported
  `SES_ASSERT_IMP(a_state_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[2:0] < 3'd5)

  // inactive never drives the power stage
  `SES_ASSERT_IMP(a_inactive_pwm, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[2:0] == ST_INACTIVE), !m_axis_tdata[3])

  // a stalled word holds
  `SES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind servo_enable_sequencer_core ses_checker u_ses_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the servo enable sequencer core.
// Control ticks go in through a bursty stream driver. A cycle-accurate
// predictor works out each status word. A monitor compares every word taken
// from the master stream field by field against the oldest prediction. The
// run covers a directed walk through the sequencer and several register
// settings with random ticks. The receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ses_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned PHASE_TICKS  = 180;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_PATTERN} rx_style_e;
  typedef enum logic [1:0] {RUN_HEALTHY, RUN_SHAKY, RUN_NOISE} run_style_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       cfg_we_i    = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index_i = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data_i  = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

  servo_enable_sequencer_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // register copies
  logic        brake_fitted = 1'b1;
  logic [15:0] hold_ticks   = 16'd200;
  logic [30:0] zero_band    = 31'd8389;

  // sequencer copy
  ses_seq_e                      sq_state = ST_INACTIVE;
  logic                          sq_ready = 1'b0;
  logic [1:0]                    sq_mode  = MODE_SPEED;
  logic [1:0]                    sq_pend  = MODE_SPEED;
  logic [WAIT_COUNT_WIDTH_DEF-1:0] sq_wait = '0;
  logic [POWER_COUNT_WIDTH-1:0]  pwr_cnt  = '0;
  logic                          pwr_ok   = 1'b0;
  logic drv_pwm = 1'b0, drv_brk = 1'b0;
  logic loop_pos = 1'b0, loop_spd = 1'b0, loop_cur = 1'b0;

  ses_item_t   tick_q[$];
  ses_result_t status_q[$];

  int err_count   = 0;
  int words_seen  = 0;
  int cycle_cnt   = 0;
  int burst_left  = 1;
  int gap_left    = 0;
  int words_taken = 0;
  int hold_left   = 0;
  int rx_cnt      = 0;
  rx_style_e rx_style = RX_FREE;

  task automatic set_loops(input logic [1:0] m, output logic bad);
    loop_pos = (m == MODE_POSITION);
    loop_spd = (m == MODE_POSITION) || (m == MODE_SPEED);
    loop_cur = (m != MODE_INVALID);
    bad      = (m == MODE_INVALID);
  endtask

  // one control tick of the enable sequencer
  task automatic step_sequencer(input ses_item_t it, output ses_result_t r);
    logic   alarm_free, run_cond, fault;
    longint spd, band;
    alarm_free = !it.error_present;
    fault      = 1'b0;
    spd        = longint'(it.speed_feedback);
    band       = longint'(zero_band);

    if (it.terminal_ready) begin
      if (!pwr_ok) begin
        pwr_cnt = pwr_cnt + 1'b1;
        if (pwr_cnt > POWER_QUAL_TICKS) begin
          pwr_cnt = '0;
          pwr_ok  = 1'b1;
        end
      end
    end else begin
      pwr_cnt = '0;
      pwr_ok  = 1'b0;
    end
    run_cond = pwr_ok && alarm_free && it.servo_on;

    case (sq_state)
      ST_INACTIVE: begin
        if (pwr_ok && alarm_free) begin
          // debug override: servo-on ignored, speed mode forced
          sq_ready = 1'b1;
          sq_mode  = MODE_SPEED;
          set_loops(sq_mode, fault);
          sq_wait  = '0;
          sq_state = ST_BRKOFF;
        end else begin
          loop_pos = 1'b0;
          loop_spd = 1'b0;
          loop_cur = 1'b0;
          sq_ready = 1'b0;
          drv_pwm  = 1'b0;
        end
      end
      ST_BRKOFF: begin
        drv_pwm = 1'b1;
        if (sq_wait < BRKOFF_TICKS && brake_fitted) begin
          sq_wait = sq_wait + 1'b1;
          drv_brk = 1'b0;
        end else begin
          drv_brk  = 1'b1;
          sq_wait  = '0;
          sq_state = ST_ACTIVE;
        end
      end
      ST_ACTIVE: begin
        if (run_cond) begin
          sq_ready = 1'b1;
          sq_pend  = it.requested_mode;
          sq_state = (sq_pend == sq_mode) ? ST_ACTIVE : ST_PREPARE;
        end else begin
          sq_ready = 1'b0;
          sq_state = ST_PREPARE;
        end
      end
      ST_PREPARE: begin
        if (sq_ready) begin
          if (spd < band && spd > -band) begin
            sq_mode = sq_pend;
            set_loops(sq_mode, fault);
            sq_state = ST_ACTIVE;
          end else if (!run_cond) begin
            sq_ready = 1'b0;
          end else begin
            sq_pend  = it.requested_mode;
            sq_state = (sq_pend == sq_mode) ? ST_ACTIVE : ST_PREPARE;
          end
        end else begin
          sq_wait  = '0;
          sq_state = ST_PWMOFF;
        end
      end
      ST_PWMOFF: begin
        drv_brk = 1'b0;
        if (!pwr_ok || !alarm_free) begin
          drv_pwm  = 1'b0;
          sq_wait  = '0;
          sq_state = ST_INACTIVE;
        end else begin
          sq_wait = sq_wait + 1'b1;
          if (brake_fitted && sq_wait < (hold_ticks >> 1)) begin
            drv_pwm = 1'b1;
          end else begin
            drv_pwm  = 1'b0;
            sq_wait  = '0;
            sq_state = ST_INACTIVE;
          end
        end
      end
      default: begin
        sq_state = ST_INACTIVE;
        fault    = 1'b1;
      end
    endcase

    r.sequencer_state   = sq_state;
    r.pwm_enable        = drv_pwm;
    r.brake_release     = drv_brk;
    r.position_loop_run = loop_pos;
    r.speed_loop_run    = loop_spd;
    r.current_loop_run  = loop_cur;
    r.servo_ready       = alarm_free && pwr_ok;
    r.no_alarm          = alarm_free;
    r.power_ready       = pwr_ok;
    r.kernel_fault      = fault;
    r.active_mode       = sq_mode;
    r.run_allowed       = sq_ready;
  endtask

  // stream driver: bursts of random length with random gaps
  always @(posedge clk_i) begin : drive_blk
    ses_result_t r;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_sequencer(tick_q.pop_front(), r);
        status_q.push_back(r);
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          if ($urandom_range(0, 2) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 30 : 5);
        end
      end
      // a word not yet taken stays on the bus
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_TDATA_WIDTH-37){1'b0}}, tick_q[0].speed_feedback,
                            tick_q[0].requested_mode, tick_q[0].servo_on,
                            tick_q[0].error_present, tick_q[0].terminal_ready};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls, with a long hold-off now and then so the input backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_taken++;
        if (words_taken % 600 == 300) hold_left = 160;
      end
      rx_cnt++;
      if (rx_cnt % 97 == 0) rx_style = rx_style_e'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_style)
          RX_FREE:   m_axis_tready <= 1'b1;
          RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready <= (rx_cnt[2:0] != 3'd5);
        endcase
      end
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("word %0d: %s got %0h want %0h", words_seen, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin : watch_blk
    ses_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (status_q.size() == 0) begin
        report_mismatch("unexpected word", int'(m_axis_tdata), 0);
      end else begin
        want = status_q.pop_front();
        check_field("sequencer_state", int'(m_axis_tdata[2:0]),
                    int'(want.sequencer_state));
        check_field("pwm_enable", int'(m_axis_tdata[3]), int'(want.pwm_enable));
        check_field("brake_release", int'(m_axis_tdata[4]), int'(want.brake_release));
        check_field("position_loop_run", int'(m_axis_tdata[5]),
                    int'(want.position_loop_run));
        check_field("speed_loop_run", int'(m_axis_tdata[6]), int'(want.speed_loop_run));
        check_field("current_loop_run", int'(m_axis_tdata[7]),
                    int'(want.current_loop_run));
        check_field("servo_ready", int'(m_axis_tdata[8]), int'(want.servo_ready));
        check_field("no_alarm", int'(m_axis_tdata[9]), int'(want.no_alarm));
        check_field("power_ready", int'(m_axis_tdata[10]), int'(want.power_ready));
        check_field("kernel_fault", int'(m_axis_tdata[11]), int'(want.kernel_fault));
        check_field("active_mode", int'(m_axis_tdata[13:12]), int'(want.active_mode));
        check_field("run_allowed", int'(m_axis_tdata[14]), int'(want.run_allowed));
      end
      words_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("servo_enable_sequencer_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_BRAKE_PRESENT:    brake_fitted = val[0];
      REG_BRAKE_HOLD_TIME:  hold_ticks   = val[15:0];
      REG_ZERO_SPEED_LIMIT: zero_band    = val[30:0];
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic term, input logic err, input logic srv,
                           input logic [1:0] mode, input logic [31:0] spd);
    ses_item_t it;
    it.terminal_ready = term;
    it.error_present  = err;
    it.servo_on       = srv;
    it.requested_mode = mode;
    it.speed_feedback = spd;
    tick_q.push_back(it);
  endtask

  // block idle: nothing queued, nothing on the bus, every word back
  task automatic drain();
    while (tick_q.size() != 0 || s_axis_tvalid || status_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // speeds clustered around the zero-speed band and its edges
  function automatic logic [31:0] pick_speed();
    longint b, v;
    b = longint'(zero_band);
    case ($urandom_range(0, 7))
      0, 1: v = longint'($urandom_range(0, 32'(2 * b))) - b;
      2, 3: v = b + longint'($urandom_range(0, 4)) - 2;
      4:    v = 0;
      5:    v = longint'($urandom);
      6:    v = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
      default: v = b + longint'($urandom_range(0, 1000));
    endcase
    if ($urandom_range(0, 1) != 0) v = -v;
    return v[31:0];
  endfunction

  function automatic logic [1:0] pick_mode();
    if ($urandom_range(0, 7) == 0) return MODE_INVALID;
    return 2'($urandom_range(0, 2));
  endfunction

  task automatic add_run(inout int made);
    run_style_e style;
    int         len, k;
    logic [1:0] want_mode;
    k         = $urandom_range(0, 9);
    style     = (k < 7) ? RUN_HEALTHY : (k < 9) ? RUN_SHAKY : RUN_NOISE;
    len       = $urandom_range(8, 60);
    want_mode = pick_mode();
    repeat (len) begin
      if ($urandom_range(0, 5) == 0) want_mode = pick_mode();
      case (style)
        RUN_HEALTHY: push_tick($urandom_range(0, 63) != 0, $urandom_range(0, 79) == 0,
                               $urandom_range(0, 23) != 0, want_mode, pick_speed());
        RUN_SHAKY:   push_tick($urandom_range(0, 5) != 0, $urandom_range(0, 5) == 0,
                               $urandom_range(0, 3) != 0, want_mode, pick_speed());
        default:     push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                               $urandom);
      endcase
      made++;
    end
  endtask

  task automatic run_phase(input logic brk, input logic [15:0] hold,
                           input logic [30:0] band, input int n_items);
    logic [30:0] noise;
    int          made;
    noise = 31'($urandom);
    write_reg(REG_BRAKE_PRESENT, {noise[30:1], brk});
    noise = 31'($urandom);
    write_reg(REG_BRAKE_HOLD_TIME, {noise[30:16], hold});
    write_reg(REG_ZERO_SPEED_LIMIT, band);
    noise = 31'($urandom);
    write_reg(REG_SPARE, noise);
    made = 0;
    while (made < n_items / 2) add_run(made);
    // sender pauses until every status word is back
    drain();
    while (made < n_items) add_run(made);
    drain();
  endtask

  initial begin : stim
    logic [30:0] noise;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk with no brake so the waits stay short
    noise = 31'($urandom);
    write_reg(REG_BRAKE_PRESENT, {noise[30:1], 1'b0});
    push_tick(1'b0, 1'b0, 1'b0, MODE_POSITION, 32'd0);
    push_tick(1'b1, 1'b1, 1'b1, MODE_INVALID, 32'h8000_0000);
    repeat (7) push_tick(1'b1, 1'b0, 1'b1, MODE_SPEED, 32'd0);
    // ninth ready tick: power qualified, leaves inactive at once
    push_tick(1'b1, 1'b0, 1'b0, MODE_TORQUE, 32'h7FFF_FFFF);
    push_tick(1'b1, 1'b0, 1'b1, MODE_SPEED, 32'd0);
    // mode change held in prepare until speed is inside the band
    push_tick(1'b1, 1'b0, 1'b1, MODE_POSITION, 32'd8389);
    push_tick(1'b1, 1'b0, 1'b1, MODE_POSITION, 32'd8389);
    push_tick(1'b1, 1'b0, 1'b1, MODE_POSITION, -32'sd8388);
    push_tick(1'b1, 1'b0, 1'b1, MODE_TORQUE, 32'h7FFF_FFFF);
    push_tick(1'b1, 1'b0, 1'b1, MODE_TORQUE, 32'd8388);
    // invalid mode adopted: loops off, kernel fault
    push_tick(1'b1, 1'b0, 1'b1, MODE_INVALID, 32'd0);
    push_tick(1'b1, 1'b0, 1'b1, MODE_INVALID, 32'd0);
    push_tick(1'b1, 1'b0, 1'b1, MODE_SPEED, -32'sd8389);
    // servo-on drops while too fast: ready cleared, then pwm-off wait
    push_tick(1'b1, 1'b0, 1'b0, MODE_SPEED, -32'sd8389);
    push_tick(1'b1, 1'b0, 1'b0, MODE_SPEED, -32'sd8389);
    push_tick(1'b1, 1'b0, 1'b0, MODE_SPEED, 32'd0);
    push_tick(1'b1, 1'b0, 1'b0, MODE_SPEED, 32'd0);
    push_tick(1'b1, 1'b0, 1'b1, MODE_SPEED, 32'd0);
    push_tick(1'b1, 1'b1, 1'b1, MODE_SPEED, 32'h7FFF_FFFF);
    push_tick(1'b0, 1'b1, 1'b1, MODE_TORQUE, 32'h8000_0000);
    drain();

    run_phase(1'b1, 16'd200, 31'd8389, PHASE_TICKS);
    run_phase(1'b1, 16'd0, 31'd0, PHASE_TICKS);
    run_phase(1'b1, 16'hFFFF, 31'h7FFF_FFFF, PHASE_TICKS);
    run_phase(1'b0, 16'd1, 31'd1, PHASE_TICKS);
    run_phase(1'b1, 16'd40, 31'd1000, PHASE_TICKS);
    run_phase(1'b1, 16'($urandom_range(2, 64)), 31'($urandom_range(0, 50000)), PHASE_TICKS);
    run_phase(1'($urandom), 16'($urandom), 31'($urandom), PHASE_TICKS);
    run_phase(1'b1, 16'd16, 31'd100000, PHASE_TICKS);

    if (err_count == 0) begin
      $display("servo_enable_sequencer_core: match");
    end else begin
      $display("servo_enable_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/ses_pkg.sv
rtl/ses_step.sv
rtl/servo_enable_sequencer_core.sv
rtl/ses_checker.sv
tb/tb.sv
